// ===== hdl/mvna_pkg.sv =====
// Shared types, constants and helper functions of the vertex normal accumulator.
package mvna_pkg;

    localparam int VERTEX_DEPTH = 1024;
    localparam int VTX_AW = $clog2(VERTEX_DEPTH);
    localparam int IDX_W = 10;
    localparam int CRD_W = 16;
    localparam int ACC_W = 40;
    localparam int TAG_W = 8;
    localparam int NRM_W = 16;
    localparam int VTX_W = 3 * CRD_W;
    localparam int ACC_ENTRY_W = TAG_W + 3 * ACC_W;

    typedef logic [VTX_AW-1:0] t_addr;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_FACE  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_VWR,
        DP_VRD,
        DP_EDGE,
        DP_MUL,
        DP_CROSS,
        DP_ARD,
        DP_AWR,
        DP_NLOAD,
        DP_SHIFT,
        DP_SQ,
        DP_SQADD,
        DP_RINIT,
        DP_RSTEP,
        DP_DINIT,
        DP_DSTEP,
        DP_QSTORE,
        DP_DEG,
        DP_EPOCH,
        DP_CLR,
        DP_RES
    } t_dp_cmd;

    typedef struct packed {
        t_dp_cmd    cmd;
        logic [1:0] lane;
    } t_dp_ctl;

    typedef struct packed {
        t_op  op;
        logic face_ok;
        logic idx_ok;
        logic zero;
        logic norm_ok;
        logic root_last;
        logic div_last;
        logic clr_last;
        logic epoch_max;
    } t_dp_sts;

    function automatic logic idx_in_range(input logic [IDX_W-1:0] idx);
        return 32'(idx) < 32'(VERTEX_DEPTH);
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [34:0]      b
    );
        logic signed [ACC_W:0] s;
        s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return s[ACC_W-1:0];
    endfunction

endpackage

// ===== hdl/mesh_vertex_normal_accumulator.sv =====
// Top level of the area-weighted vertex normal accumulator.
// Every input word gives exactly one output word; only a read (op 3) carries a
// normal, all other ops return zeros. Items are handled one at a time, and the
// next word is taken while a finished result waits in the output register.
// A face makes three vertex reads, then three read-modify-writes of the
// accumulator RAM; a read of a nonzero normal runs the one-bit normalizing
// shift (up to 29 steps), the 32-step square root and three 15-step divides.
// After reset, and after a clear that wraps the epoch from 255 to 0, a
// clearing pass walks all VERTEX_DEPTH (1024) entries of the accumulator RAM;
// no word is accepted during it.
module mesh_vertex_normal_accumulator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_op,
    input  logic [mvna_pkg::IDX_W-1:0]        i_vertex_index,
    input  logic signed [mvna_pkg::CRD_W-1:0] i_coord_x,
    input  logic signed [mvna_pkg::CRD_W-1:0] i_coord_y,
    input  logic signed [mvna_pkg::CRD_W-1:0] i_coord_z,
    input  logic [mvna_pkg::IDX_W-1:0]        i_corner_b,
    input  logic [mvna_pkg::IDX_W-1:0]        i_corner_c,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [mvna_pkg::NRM_W-1:0] o_normal_x,
    output logic signed [mvna_pkg::NRM_W-1:0] o_normal_y,
    output logic signed [mvna_pkg::NRM_W-1:0] o_normal_z,
    output logic                              o_degenerate
);
    import mvna_pkg::*;

    t_dp_ctl ctl;
    t_dp_sts sts;

    mvna_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    mvna_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_op           (i_op),
        .i_vertex_index (i_vertex_index),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_coord_z      (i_coord_z),
        .i_corner_b     (i_corner_b),
        .i_corner_c     (i_corner_c),
        .o_sts          (sts),
        .o_normal_x     (o_normal_x),
        .o_normal_y     (o_normal_y),
        .o_normal_z     (o_normal_z),
        .o_degenerate   (o_degenerate)
    );
endmodule

// ===== hdl/mvna_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module mvna_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/mvna_dp.sv =====
// Datapath: vertex and accumulator stores, cross product, normalize, root and divide units.
module mvna_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mvna_pkg::t_dp_ctl                i_ctl,
    input  logic [1:0]                       i_op,
    input  logic [mvna_pkg::IDX_W-1:0]       i_vertex_index,
    input  logic signed [mvna_pkg::CRD_W-1:0] i_coord_x,
    input  logic signed [mvna_pkg::CRD_W-1:0] i_coord_y,
    input  logic signed [mvna_pkg::CRD_W-1:0] i_coord_z,
    input  logic [mvna_pkg::IDX_W-1:0]       i_corner_b,
    input  logic [mvna_pkg::IDX_W-1:0]       i_corner_c,
    output mvna_pkg::t_dp_sts                o_sts,
    output logic signed [mvna_pkg::NRM_W-1:0] o_normal_x,
    output logic signed [mvna_pkg::NRM_W-1:0] o_normal_y,
    output logic signed [mvna_pkg::NRM_W-1:0] o_normal_z,
    output logic                             o_degenerate
);
    import mvna_pkg::*;

    logic [1:0]                r_op;
    logic [IDX_W-1:0]          r_corner [3];
    logic signed [CRD_W-1:0]   r_crd [3];
    logic signed [CRD_W-1:0]   r_pos [3][3];
    logic                      r_vcap;
    logic [1:0]                r_vcap_lane;
    logic signed [CRD_W:0]     r_e1 [3];
    logic signed [CRD_W:0]     r_e2 [3];
    logic signed [33:0]        r_p [6];
    logic signed [34:0]        r_n [3];
    logic [ACC_W-1:0]          r_mag [3];
    logic                      r_neg [3];
    logic [59:0]               r_prod;
    logic [61:0]               r_sum;
    logic [62:0]               r_rv;
    logic [62:0]               r_rr;
    logic [62:0]               r_rbit;
    logic [31:0]               r_rem;
    logic [14:0]               r_dlow;
    logic [14:0]               r_dq;
    logic [3:0]                r_dcnt;
    logic signed [NRM_W-1:0]   r_nrm [3];
    logic                      r_deg;
    logic signed [NRM_W-1:0]   r_out [3];
    logic                      r_out_deg;
    logic [TAG_W-1:0]          r_epoch;
    t_addr                     r_clr_addr;

    logic [IDX_W-1:0]          sel_idx;
    logic [ACC_W-1:0]          sel_mag;
    logic [VTX_W-1:0]          vtx_rdata;
    logic [ACC_ENTRY_W-1:0]    acc_rdata;
    logic                      vtx_we;
    logic                      acc_we;
    t_addr                     acc_waddr;
    logic [ACC_ENTRY_W-1:0]    acc_wdata;
    logic signed [ACC_W-1:0]   acc_live [3];
    logic [ACC_W-1:0]          mag_or;
    logic [62:0]               root_try;
    logic [30:0]               len;
    logic [44:0]               num;
    logic [31:0]               div_try;
    logic [NRM_W-1:0]          q16;

    always_comb begin
        case (i_ctl.lane)
            2'd0:    sel_idx = r_corner[0];
            2'd1:    sel_idx = r_corner[1];
            2'd2:    sel_idx = r_corner[2];
            default: sel_idx = r_corner[0];
        endcase
        case (i_ctl.lane)
            2'd0:    sel_mag = r_mag[0];
            2'd1:    sel_mag = r_mag[1];
            2'd2:    sel_mag = r_mag[2];
            default: sel_mag = r_mag[0];
        endcase
    end

    assign vtx_we = (i_ctl.cmd == DP_VWR) && idx_in_range(r_corner[0]);

    mvna_ram #(.W(VTX_W), .D(VERTEX_DEPTH)) u_vtx_ram (
        .i_clk   (i_clk),
        .i_we    (vtx_we),
        .i_waddr (VTX_AW'(r_corner[0])),
        .i_wdata ({r_crd[2], r_crd[1], r_crd[0]}),
        .i_raddr (VTX_AW'(sel_idx)),
        .o_rdata (vtx_rdata)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            acc_live[k] = (acc_rdata[ACC_ENTRY_W-1 -: TAG_W] == r_epoch) ?
                          acc_rdata[k*ACC_W +: ACC_W] : '0;
        end
        acc_we    = 1'b0;
        acc_waddr = VTX_AW'(sel_idx);
        acc_wdata = {r_epoch, sat_add(acc_live[2], r_n[2]),
                     sat_add(acc_live[1], r_n[1]), sat_add(acc_live[0], r_n[0])};
        if (i_ctl.cmd == DP_AWR) begin
            acc_we = 1'b1;
        end else if (i_ctl.cmd == DP_CLR) begin
            acc_we    = 1'b1;
            acc_waddr = r_clr_addr;
            acc_wdata = '0;
        end
    end

    mvna_ram #(.W(ACC_ENTRY_W), .D(VERTEX_DEPTH)) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (acc_waddr),
        .i_wdata (acc_wdata),
        .i_raddr (VTX_AW'(sel_idx)),
        .o_rdata (acc_rdata)
    );

    assign mag_or   = r_mag[0] | r_mag[1] | r_mag[2];
    assign root_try = r_rr + r_rbit;
    assign len      = r_rr[30:0];
    assign num      = 45'({sel_mag[29:0], 14'b0}) + 45'(len[30:1]);
    assign div_try  = {r_rem[30:0], r_dlow[14]};
    assign q16      = (r_dq > 15'd16384) ? NRM_W'(16384) : NRM_W'(r_dq);

    always_comb begin
        o_sts.op        = t_op'(r_op);
        o_sts.face_ok   = idx_in_range(r_corner[0]) && idx_in_range(r_corner[1]) &&
                          idx_in_range(r_corner[2]);
        o_sts.idx_ok    = idx_in_range(r_corner[0]);
        o_sts.zero      = (mag_or == '0);
        o_sts.norm_ok   = (mag_or[ACC_W-1:30] == '0) && mag_or[29];
        o_sts.root_last = r_rbit[0];
        o_sts.div_last  = (r_dcnt == 4'd14);
        o_sts.clr_last  = (32'(r_clr_addr) == 32'(VERTEX_DEPTH - 1));
        o_sts.epoch_max = (r_epoch == '1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcap     <= 1'b0;
            r_epoch    <= '0;
            r_clr_addr <= '0;
            r_out_deg  <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_out[k] <= '0;
            end
        end else begin
            r_vcap      <= (i_ctl.cmd == DP_VRD);
            r_vcap_lane <= i_ctl.lane;
            if (r_vcap) begin
                for (int k = 0; k < 3; k++) begin
                    r_pos[r_vcap_lane][k] <= vtx_rdata[k*CRD_W +: CRD_W];
                end
            end
            case (i_ctl.cmd)
                DP_LOAD: begin
                    r_op      <= i_op;
                    r_corner[0] <= i_vertex_index;
                    r_corner[1] <= i_corner_b;
                    r_corner[2] <= i_corner_c;
                    r_crd[0]  <= i_coord_x;
                    r_crd[1]  <= i_coord_y;
                    r_crd[2]  <= i_coord_z;
                    r_deg     <= 1'b0;
                    for (int k = 0; k < 3; k++) begin
                        r_nrm[k] <= '0;
                    end
                end
                DP_EDGE: begin
                    for (int k = 0; k < 3; k++) begin
                        r_e1[k] <= (CRD_W+1)'(r_pos[1][k]) - (CRD_W+1)'(r_pos[0][k]);
                        r_e2[k] <= (CRD_W+1)'(r_pos[2][k]) - (CRD_W+1)'(r_pos[0][k]);
                    end
                end
                DP_MUL: begin
                    r_p[0] <= r_e1[1] * r_e2[2];
                    r_p[1] <= r_e1[2] * r_e2[1];
                    r_p[2] <= r_e1[2] * r_e2[0];
                    r_p[3] <= r_e1[0] * r_e2[2];
                    r_p[4] <= r_e1[0] * r_e2[1];
                    r_p[5] <= r_e1[1] * r_e2[0];
                end
                DP_CROSS: begin
                    for (int k = 0; k < 3; k++) begin
                        r_n[k] <= 35'(r_p[2*k]) - 35'(r_p[2*k+1]);
                    end
                end
                DP_NLOAD: begin
                    r_sum <= '0;
                    for (int k = 0; k < 3; k++) begin
                        r_neg[k] <= acc_live[k][ACC_W-1];
                        r_mag[k] <= acc_live[k][ACC_W-1] ? ACC_W'(-acc_live[k])
                                                         : ACC_W'(acc_live[k]);
                    end
                end
                DP_SHIFT: begin
                    for (int k = 0; k < 3; k++) begin
                        if (mag_or[ACC_W-1:30] != '0) begin
                            r_mag[k] <= r_mag[k] >> 1;
                        end else begin
                            r_mag[k] <= r_mag[k] << 1;
                        end
                    end
                end
                DP_SQ: begin
                    r_prod <= sel_mag[29:0] * sel_mag[29:0];
                end
                DP_SQADD: begin
                    r_sum <= r_sum + 62'(r_prod);
                end
                DP_RINIT: begin
                    r_rv   <= 63'(r_sum);
                    r_rr   <= '0;
                    r_rbit <= {1'b1, 62'b0};
                end
                DP_RSTEP: begin
                    if (r_rv >= root_try) begin
                        r_rv <= r_rv - root_try;
                        r_rr <= (r_rr >> 1) + r_rbit;
                    end else begin
                        r_rr <= r_rr >> 1;
                    end
                    r_rbit <= r_rbit >> 2;
                end
                DP_DINIT: begin
                    r_rem  <= 32'(num[44:15]);
                    r_dlow <= num[14:0];
                    r_dq   <= '0;
                    r_dcnt <= '0;
                end
                DP_DSTEP: begin
                    if (div_try >= {1'b0, len}) begin
                        r_rem <= div_try - {1'b0, len};
                        r_dq  <= {r_dq[13:0], 1'b1};
                    end else begin
                        r_rem <= div_try;
                        r_dq  <= {r_dq[13:0], 1'b0};
                    end
                    r_dlow <= r_dlow << 1;
                    r_dcnt <= r_dcnt + 4'd1;
                end
                DP_QSTORE: begin
                    r_nrm[i_ctl.lane] <= r_neg[i_ctl.lane] ? q16 : -q16;
                end
                DP_DEG: begin
                    r_deg <= 1'b1;
                end
                DP_EPOCH: begin
                    r_epoch <= r_epoch + 1'b1;
                end
                DP_CLR: begin
                    r_clr_addr <= o_sts.clr_last ? '0 : r_clr_addr + 1'b1;
                end
                DP_RES: begin
                    r_out_deg <= r_deg;
                    for (int k = 0; k < 3; k++) begin
                        r_out[k] <= r_nrm[k];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_normal_x   = r_out[0];
    assign o_normal_y   = r_out[1];
    assign o_normal_z   = r_out[2];
    assign o_degenerate = r_out_deg;
endmodule

// ===== hdl/mvna_ctrl.sv =====
// Controller state machine that sequences the datapath for each operation.
module mvna_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  mvna_pkg::t_dp_sts i_sts,
    output mvna_pkg::t_dp_ctl o_ctl
);
    import mvna_pkg::*;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_DISPATCH, S_VRD, S_VWAIT, S_EDGE, S_MUL, S_CROSS,
        S_ARD, S_AWR, S_NRD, S_NLOAD, S_NCHK, S_SHIFT, S_SQ, S_SQADD,
        S_RINIT, S_RSTEP, S_DINIT, S_DSTEP, S_QSTORE, S_WRAP, S_DONE
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_lane, n_lane;
    logic       r_out_valid, n_out_valid;
    t_dp_cmd    cmd;

    always_comb begin
        n_state     = r_state;
        n_lane      = r_lane;
        n_out_valid = r_out_valid && !i_out_ready;
        cmd         = DP_NOP;
        case (r_state)
            S_INIT: begin
                cmd = DP_CLR;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd     = DP_LOAD;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_lane = 2'd0;
                case (i_sts.op)
                    OP_WRITE: begin
                        cmd     = DP_VWR;
                        n_state = S_DONE;
                    end
                    OP_FACE: begin
                        n_state = i_sts.face_ok ? S_VRD : S_DONE;
                    end
                    OP_CLEAR: begin
                        cmd     = DP_EPOCH;
                        n_state = i_sts.epoch_max ? S_WRAP : S_DONE;
                    end
                    OP_READ: begin
                        if (i_sts.idx_ok) begin
                            n_state = S_NRD;
                        end else begin
                            cmd     = DP_DEG;
                            n_state = S_DONE;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_VRD: begin
                cmd = DP_VRD;
                if (r_lane == 2'd2) begin
                    n_state = S_VWAIT;
                end else begin
                    n_lane = r_lane + 2'd1;
                end
            end
            S_VWAIT: n_state = S_EDGE;
            S_EDGE: begin
                cmd     = DP_EDGE;
                n_state = S_MUL;
            end
            S_MUL: begin
                cmd     = DP_MUL;
                n_state = S_CROSS;
            end
            S_CROSS: begin
                cmd     = DP_CROSS;
                n_lane  = 2'd0;
                n_state = S_ARD;
            end
            S_ARD: begin
                cmd     = DP_ARD;
                n_state = S_AWR;
            end
            S_AWR: begin
                cmd = DP_AWR;
                if (r_lane == 2'd2) begin
                    n_state = S_DONE;
                end else begin
                    n_lane  = r_lane + 2'd1;
                    n_state = S_ARD;
                end
            end
            S_NRD: begin
                cmd     = DP_ARD;
                n_state = S_NLOAD;
            end
            S_NLOAD: begin
                cmd     = DP_NLOAD;
                n_state = S_NCHK;
            end
            S_NCHK: begin
                if (i_sts.zero) begin
                    cmd     = DP_DEG;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (i_sts.norm_ok) begin
                    n_lane  = 2'd0;
                    n_state = S_SQ;
                end else begin
                    cmd = DP_SHIFT;
                end
            end
            S_SQ: begin
                cmd     = DP_SQ;
                n_state = S_SQADD;
            end
            S_SQADD: begin
                cmd = DP_SQADD;
                if (r_lane == 2'd2) begin
                    n_state = S_RINIT;
                end else begin
                    n_lane  = r_lane + 2'd1;
                    n_state = S_SQ;
                end
            end
            S_RINIT: begin
                cmd     = DP_RINIT;
                n_state = S_RSTEP;
            end
            S_RSTEP: begin
                cmd = DP_RSTEP;
                if (i_sts.root_last) begin
                    n_lane  = 2'd0;
                    n_state = S_DINIT;
                end
            end
            S_DINIT: begin
                cmd     = DP_DINIT;
                n_state = S_DSTEP;
            end
            S_DSTEP: begin
                cmd = DP_DSTEP;
                if (i_sts.div_last) n_state = S_QSTORE;
            end
            S_QSTORE: begin
                cmd = DP_QSTORE;
                if (r_lane == 2'd2) begin
                    n_state = S_DONE;
                end else begin
                    n_lane  = r_lane + 2'd1;
                    n_state = S_DINIT;
                end
            end
            S_WRAP: begin
                cmd = DP_CLR;
                if (i_sts.clr_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd         = DP_RES;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_lane      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lane      <= n_lane;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_ctl.cmd   = cmd;
    assign o_ctl.lane  = r_lane;
endmodule

// ===== tb/sv/mvna_normal_checker.sv =====
// Checker that predicts vertex normals from accepted words and compares the results.
module mvna_normal_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [1:0]                        i_op,
    input  logic [mvna_pkg::IDX_W-1:0]        i_vertex_index,
    input  logic signed [mvna_pkg::CRD_W-1:0] i_coord_x,
    input  logic signed [mvna_pkg::CRD_W-1:0] i_coord_y,
    input  logic signed [mvna_pkg::CRD_W-1:0] i_coord_z,
    input  logic [mvna_pkg::IDX_W-1:0]        i_corner_b,
    input  logic [mvna_pkg::IDX_W-1:0]        i_corner_c,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic signed [mvna_pkg::NRM_W-1:0] i_normal_x,
    input  logic signed [mvna_pkg::NRM_W-1:0] i_normal_y,
    input  logic signed [mvna_pkg::NRM_W-1:0] i_normal_z,
    input  logic                              i_degenerate,
    output int                                o_fail_count,
    output int                                o_pending
);
    import mvna_pkg::*;

    localparam logic signed [63:0] SUM_MAX = 64'sd549755813887;
    localparam logic signed [63:0] SUM_MIN = -64'sd549755813888;

    typedef struct packed {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               degen;
    } t_normal;

    logic signed [15:0] pos_table [VERTEX_DEPTH][3];
    logic signed [63:0] sum_table [VERTEX_DEPTH][3];
    logic [7:0]         tag_table [VERTEX_DEPTH];
    logic [7:0]         epoch_now;
    t_normal            normal_queue [$];

    function automatic logic signed [63:0] live_sum(int v, int k);
        return (tag_table[v] == epoch_now) ? sum_table[v][k] : 64'sd0;
    endfunction

    function automatic logic [63:0] int_root(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic add_face_normal(int v, logic signed [63:0] n [3]);
        logic signed [63:0] s;
        for (int k = 0; k < 3; k++) begin
            s = live_sum(v, k) + n[k];
            if (s > SUM_MAX) s = SUM_MAX;
            if (s < SUM_MIN) s = SUM_MIN;
            sum_table[v][k] = s;
        end
        tag_table[v] = epoch_now;
    endtask

    function automatic t_normal unit_normal(int v);
        t_normal            res;
        logic [63:0]        mag [3];
        logic               neg [3];
        logic [63:0]        big;
        logic [63:0]        sq;
        logic [63:0]        len;
        logic [63:0]        q;
        logic signed [63:0] a;
        int                 nbits;
        res = '0;
        big = 0;
        sq = 0;
        for (int k = 0; k < 3; k++) begin
            a = live_sum(v, k);
            neg[k] = a < 0;
            mag[k] = neg[k] ? -a : a;
            if (mag[k] > big) big = mag[k];
        end
        if (big == 0) begin
            res.degen = 1'b1;
            return res;
        end
        nbits = 0;
        while (big != 0) begin
            nbits++;
            big = big >> 1;
        end
        for (int k = 0; k < 3; k++) begin
            if (nbits > 30) mag[k] = mag[k] >> (nbits - 30);
            else if (nbits < 30) mag[k] = mag[k] << (30 - nbits);
            sq = sq + mag[k] * mag[k];
        end
        len = int_root(sq);
        for (int k = 0; k < 3; k++) begin
            q = (mag[k] * 16384 + len / 2) / len;
            if (q > 16384) q = 16384;
            q = neg[k] ? q : -q;
            if (k == 0) res.nx = q[15:0];
            else if (k == 1) res.ny = q[15:0];
            else res.nz = q[15:0];
        end
        return res;
    endfunction

    task automatic predict_word();
        t_normal            res;
        logic signed [63:0] e1 [3];
        logic signed [63:0] e2 [3];
        logic signed [63:0] n [3];
        int                 va;
        int                 vb;
        int                 vc;
        res = '0;
        va = i_vertex_index;
        vb = i_corner_b;
        vc = i_corner_c;
        case (t_op'(i_op))
            OP_WRITE: begin
                if (va < VERTEX_DEPTH) begin
                    pos_table[va][0] = i_coord_x;
                    pos_table[va][1] = i_coord_y;
                    pos_table[va][2] = i_coord_z;
                end
            end
            OP_FACE: begin
                if (va < VERTEX_DEPTH && vb < VERTEX_DEPTH && vc < VERTEX_DEPTH) begin
                    for (int k = 0; k < 3; k++) begin
                        e1[k] = 64'(pos_table[vb][k]) - 64'(pos_table[va][k]);
                        e2[k] = 64'(pos_table[vc][k]) - 64'(pos_table[va][k]);
                    end
                    n[0] = e1[1] * e2[2] - e1[2] * e2[1];
                    n[1] = e1[2] * e2[0] - e1[0] * e2[2];
                    n[2] = e1[0] * e2[1] - e1[1] * e2[0];
                    add_face_normal(va, n);
                    add_face_normal(vb, n);
                    add_face_normal(vc, n);
                end
            end
            OP_CLEAR: begin
                epoch_now = epoch_now + 8'd1;
                if (epoch_now == 0) begin
                    for (int v = 0; v < VERTEX_DEPTH; v++) begin
                        tag_table[v] = 0;
                        for (int k = 0; k < 3; k++) sum_table[v][k] = 0;
                    end
                end
            end
            default: begin
                if (va < VERTEX_DEPTH) res = unit_normal(va);
                else res.degen = 1'b1;
            end
        endcase
        normal_queue.push_back(res);
        o_pending = normal_queue.size();
    endtask

    task automatic check_result();
        t_normal want;
        if (normal_queue.size() == 0) begin
            $error("Result word arrived with no expectation waiting.");
            o_fail_count++;
            return;
        end
        want = normal_queue.pop_front();
        o_pending = normal_queue.size();
        if (i_normal_x !== want.nx) begin
            $error("normal_x: expected %0d, got %0d", want.nx, i_normal_x);
            o_fail_count++;
        end
        if (i_normal_y !== want.ny) begin
            $error("normal_y: expected %0d, got %0d", want.ny, i_normal_y);
            o_fail_count++;
        end
        if (i_normal_z !== want.nz) begin
            $error("normal_z: expected %0d, got %0d", want.nz, i_normal_z);
            o_fail_count++;
        end
        if (i_degenerate !== want.degen) begin
            $error("degenerate: expected %0d, got %0d", want.degen, i_degenerate);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        epoch_now = 0;
        for (int v = 0; v < VERTEX_DEPTH; v++) begin
            tag_table[v] = 0;
            for (int k = 0; k < 3; k++) begin
                sum_table[v][k] = 0;
                pos_table[v][k] = 0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) check_result();
            if (i_in_valid && i_in_ready) predict_word();
        end
    end
endmodule

// ===== tb/sv/tb_mesh_vertex_normal_accumulator.sv =====
// Testbench top that drives vertex, face, clear and read words and gives the verdict.
module tb_mesh_vertex_normal_accumulator;
    import mvna_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  op = OP_WRITE;
    logic [9:0]  vertex_index = '0;
    logic [15:0] coord_x = '0;
    logic [15:0] coord_y = '0;
    logic [15:0] coord_z = '0;
    logic [9:0]  corner_b = '0;
    logic [9:0]  corner_c = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] normal_x;
    logic [15:0] normal_y;
    logic [15:0] normal_z;
    logic        degenerate;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    logic        written [VERTEX_DEPTH];
    int          stall_mode = 0;

    always #2 i_clk = ~i_clk;

    mesh_vertex_normal_accumulator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_op(op), .i_vertex_index(vertex_index), .i_coord_x(coord_x),
        .i_coord_y(coord_y), .i_coord_z(coord_z), .i_corner_b(corner_b),
        .i_corner_c(corner_c), .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_normal_x(normal_x), .o_normal_y(normal_y), .o_normal_z(normal_z),
        .o_degenerate(degenerate)
    );

    mvna_normal_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_op(op), .i_vertex_index(vertex_index), .i_coord_x(coord_x),
        .i_coord_y(coord_y), .i_coord_z(coord_z), .i_corner_b(corner_b),
        .i_corner_c(corner_c), .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_normal_x(normal_x), .i_normal_y(normal_y), .i_normal_z(normal_z),
        .i_degenerate(degenerate), .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_word(logic [1:0] w_op, logic [9:0] va, logic [15:0] x,
                             logic [15:0] y, logic [15:0] z, logic [9:0] vb,
                             logic [9:0] vc);
        op <= w_op;
        vertex_index <= va;
        coord_x <= x;
        coord_y <= y;
        coord_z <= z;
        corner_b <= vb;
        corner_c <= vc;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        if (w_op == OP_WRITE && va < VERTEX_DEPTH) written[va] = 1'b1;
    endtask

    task automatic take_gap();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [9:0] known_vertex(int span);
        logic [9:0] v;
        v = 10'($urandom_range(0, span));
        while (!written[v]) v = 10'($urandom_range(0, span));
        return v;
    endfunction

    task automatic send_random(int span);
        int          pick;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        pick = $urandom_range(0, 99);
        x = 16'($urandom);
        y = 16'($urandom);
        z = 16'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            x = x >>> 6;
            y = y >>> 6;
        end
        if (pick < 30) begin
            send_word(OP_WRITE, 10'($urandom_range(0, span)), x, y, z, 10'($urandom),
                      10'($urandom));
        end else if (pick < 70) begin
            send_word(OP_FACE, known_vertex(span), 16'($urandom), 16'($urandom),
                      16'($urandom), known_vertex(span), ($urandom_range(0, 9) == 0) ?
                      known_vertex(span) : known_vertex(span));
        end else if (pick < 72) begin
            send_word(OP_CLEAR, 10'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 10'($urandom), 10'($urandom));
        end else begin
            send_word(OP_READ, 10'($urandom_range(0, span)), 16'($urandom),
                      16'($urandom), 16'($urandom), 10'($urandom), 10'($urandom));
        end
    endtask

    initial begin
        int   burst;
        logic paused;
        paused = 1'b0;
        for (int v = 0; v < VERTEX_DEPTH; v++) written[v] = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(OP_READ, 10'd5, 0, 0, 0, 0, 0);
        send_word(OP_WRITE, 10'd0, 16'h8000, 16'h8000, 16'h8000, 10'h3FF, 10'h3FF);
        send_word(OP_WRITE, 10'd1, 16'h7FFF, 16'h7FFF, 16'h8000, 0, 0);
        send_word(OP_WRITE, 10'd2, 16'h8000, 16'h7FFF, 16'h7FFF, 0, 0);
        send_word(OP_WRITE, 10'd1023, 16'h7FFF, 16'h8000, 16'h7FFF, 0, 0);
        send_word(OP_WRITE, 10'd3, 16'h1000, 16'h0000, 16'h0000, 0, 0);
        send_word(OP_WRITE, 10'd4, 16'h0000, 16'h1000, 16'h0000, 0, 0);
        send_word(OP_FACE, 10'd0, 0, 0, 0, 10'd1, 10'd2);
        send_word(OP_READ, 10'd0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 40; i++) begin
            send_word(OP_FACE, 10'd0, 0, 0, 0, 10'd1, 10'd1023);
            send_word(OP_FACE, 10'd2, 0, 0, 0, 10'd0, 10'd1);
        end
        send_word(OP_READ, 10'd1023, 0, 0, 0, 0, 0);
        send_word(OP_READ, 10'd1, 0, 0, 0, 0, 0);
        send_word(OP_FACE, 10'd0, 0, 0, 0, 10'd3, 10'd4);
        send_word(OP_FACE, 10'd3, 0, 0, 0, 10'd3, 10'd4);
        send_word(OP_READ, 10'd3, 0, 0, 0, 0, 0);
        send_word(OP_READ, 10'd4, 0, 0, 0, 0, 0);
        send_word(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        send_word(OP_READ, 10'd0, 0, 0, 0, 0, 0);

        for (int n = 0; n < 1300; n += burst) begin
            burst = $urandom_range(1, 20);
            for (int i = 0; i < burst; i++) send_random((n < 200) ? 7 : 1023);
            take_gap();
            if (!paused && n >= 650) begin
                paused = 1'b1;
                in_valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
        end

        // Walk the epoch through its wrap so the flash clear is exercised.
        for (int i = 0; i < 256; i++) begin
            send_word(OP_CLEAR, 0, 0, 0, 0, 0, 0);
            if (i == 250) send_word(OP_FACE, 10'd0, 0, 0, 0, 10'd1, 10'd2);
        end
        send_word(OP_READ, 10'd0, 0, 0, 0, 0, 0);
        send_word(OP_FACE, 10'd0, 0, 0, 0, 10'd3, 10'd4);
        send_word(OP_READ, 10'd4, 0, 0, 0, 0, 0);
        in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/mvna_pkg.sv
hdl/mvna_ram.sv
hdl/mvna_dp.sv
hdl/mvna_ctrl.sv
hdl/mesh_vertex_normal_accumulator.sv
tb/sv/mvna_normal_checker.sv
tb/sv/tb_mesh_vertex_normal_accumulator.sv
